// File: hdl/rsch_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsch_pkg: shared types and constants of the ray/sphere closest-hit engine
// Holds the fixed-point constants, the queued item type, the opcode and
// sequencer state encodings and a saturation helper.
// ----------------------------------------------------------------------------
package rsch_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_SPHERES = 16;
    localparam int IDX_W       = $clog2(MAX_SPHERES);
    localparam int CNT_W       = $clog2(MAX_SPHERES + 1);
    localparam int COORD_W     = 32;
    localparam int T_W         = 31;

    // Fixed-point one and the lower t bound 0.001 rounded to nearest.
    localparam logic signed [63:0] FX_ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic [T_W-1:0] T_MIN = T_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_TRACE = 1'b1
    } op_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_A,
        ST_RD,
        ST_OC,
        ST_B,
        ST_C,
        ST_D,
        ST_SQ,
        ST_NUM,
        ST_DIV,
        ST_CHK,
        ST_P,
        ST_NRM,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic                      is_trace;
        logic [IDX_W-1:0]          index;
        logic [CNT_W-1:0]          count;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
    } item_t;

    // Clamp a wide signed value into the 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sh0000_0000_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] ext64(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage
`default_nettype wire

// File: hdl/rsch_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsch_if: request and response channels of the closest-hit engine
// Valid/ready channels; an item moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface rsch_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 opcode;
    logic [rsch_pkg::IDX_W-1:0]           sphere_index;
    logic signed [rsch_pkg::COORD_W-1:0]  pos_x;
    logic signed [rsch_pkg::COORD_W-1:0]  pos_y;
    logic signed [rsch_pkg::COORD_W-1:0]  pos_z;
    logic signed [rsch_pkg::COORD_W-1:0]  dir_x;
    logic signed [rsch_pkg::COORD_W-1:0]  dir_y;
    logic signed [rsch_pkg::COORD_W-1:0]  dir_z;

    modport source (output valid, opcode, sphere_index, pos_x, pos_y, pos_z,
                    dir_x, dir_y, dir_z, input ready);
    modport sink   (input valid, opcode, sphere_index, pos_x, pos_y, pos_z,
                    dir_x, dir_y, dir_z, output ready);
endinterface

interface rsch_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 hit;
    logic [rsch_pkg::T_W-1:0]             hit_t;
    logic signed [rsch_pkg::COORD_W-1:0]  point_x;
    logic signed [rsch_pkg::COORD_W-1:0]  point_y;
    logic signed [rsch_pkg::COORD_W-1:0]  point_z;
    logic signed [rsch_pkg::COORD_W-1:0]  normal_x;
    logic signed [rsch_pkg::COORD_W-1:0]  normal_y;
    logic signed [rsch_pkg::COORD_W-1:0]  normal_z;

    modport source (output valid, hit, hit_t, point_x, point_y, point_z,
                    normal_x, normal_y, normal_z, input ready);
    modport sink   (input valid, hit, hit_t, point_x, point_y, point_z,
                    normal_x, normal_y, normal_z, output ready);
endinterface
`default_nettype wire

// File: hdl/rsch_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsch_front: request intake of the closest-hit engine
// Holds the sphere count register, classifies each item as load or trace,
// tags traces with the clamped count and queues items in a two-entry FIFO.
// ----------------------------------------------------------------------------
module rsch_front
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [rsch_pkg::CNT_W-1:0] cfg_wr_data,
    rsch_req_if.sink                        req,
    output logic                            q_valid,
    input  wire logic                       q_ready,
    output rsch_pkg::item_t                 q_item
);

    rsch_pkg::item_t          fifo_reg [2];
    logic                     wr_ptr_reg;
    logic                     wr_ptr_next;
    logic                     rd_ptr_reg;
    logic                     rd_ptr_next;
    logic [1:0]               fill_reg;
    logic [1:0]               fill_next;
    logic [rsch_pkg::CNT_W-1:0] count_reg;
    logic [rsch_pkg::CNT_W-1:0] count_clamped;
    logic                     push;
    logic                     pop;
    rsch_pkg::item_t          new_item;

    assign req.ready = (fill_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign q_valid   = (fill_reg != 2'd0);
    assign pop       = q_valid && q_ready;
    assign q_item    = fifo_reg[rd_ptr_reg];

    assign count_clamped = (count_reg > rsch_pkg::CNT_W'(rsch_pkg::MAX_SPHERES))
                         ? rsch_pkg::CNT_W'(rsch_pkg::MAX_SPHERES) : count_reg;

    always_comb
    begin
        new_item.is_trace = (rsch_pkg::op_t'(req.opcode) == rsch_pkg::OP_TRACE);
        new_item.index    = req.sphere_index;
        new_item.count    = count_clamped;
        new_item.pos_x    = req.pos_x;
        new_item.pos_y    = req.pos_y;
        new_item.pos_z    = req.pos_z;
        new_item.dir_x    = req.dir_x;
        new_item.dir_y    = req.dir_y;
        new_item.dir_z    = req.dir_z;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule
`default_nettype wire

// File: hdl/rsch_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsch_back: execution sequencer of the closest-hit engine
// Writes sphere centers and walks traces over the table with one shared
// multiplier, a bit-serial square root and a restoring divider.
// ----------------------------------------------------------------------------
module rsch_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  rsch_pkg::item_t      q_item,
    rsch_rsp_if.source           rsp
);

    localparam int ACC_W = 64 - rsch_pkg::FRAC_BITS + 2;
    localparam int NUM_W = 34;
    localparam int DVD_W = NUM_W - 1 + rsch_pkg::FRAC_BITS;

    typedef logic signed [31:0] vec3_t [3];

    // Sphere table.
    logic signed [31:0] tab_x [rsch_pkg::MAX_SPHERES];
    logic signed [31:0] tab_y [rsch_pkg::MAX_SPHERES];
    logic signed [31:0] tab_z [rsch_pkg::MAX_SPHERES];

    rsch_pkg::state_t   state_reg, state_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [4:0]         it_reg, it_next;
    logic [rsch_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [rsch_pkg::CNT_W-1:0] nsph_reg, nsph_next;
    logic               rsel_reg, rsel_next;
    logic               found_reg, found_next;
    logic               rsp_valid_reg, rsp_valid_next;

    vec3_t              o_reg, o_next, d_reg, d_next, c_reg;
    vec3_t              oc_reg, oc_next, bp_reg, bp_next, bn_reg, bn_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next, acc_sum;
    logic signed [31:0] a_reg, a_next, b_reg, b_next, cc_reg, cc_next;
    logic [63:0]        b2_reg, b2_next;
    logic [63:0]        rad_reg, rad_next;
    logic [33:0]        rem_reg, rem_next;
    logic [31:0]        root_reg, root_next;
    logic [30:0]        drem_reg, drem_next, dq_reg, dq_next;
    logic [rsch_pkg::T_W-1:0] t_reg, t_next, best_t_reg, best_t_next;
    logic [31:0]        closest_reg, closest_next;
    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_fx;
    logic signed [31:0] mul_a, mul_b;

    logic               out_hit_reg, out_hit_next;
    logic [rsch_pkg::T_W-1:0] out_t_reg, out_t_next;
    vec3_t              out_p_reg, out_p_next, out_n_reg, out_n_next;

    // Scratch values of the arithmetic steps.
    logic signed [64:0] disc;
    logic [35:0]        sq_sh, sq_trial, sq_diff;
    logic signed [NUM_W-1:0] num;
    logic [DVD_W-1:0]   dvd;
    logic [31:0]        dv_sh, dv_diff;
    logic               dv_ge;

    function automatic logic signed [31:0] pick3(input vec3_t v, input logic [1:0] k);
        logic signed [31:0] r;
        case (k)
            2'd0:    r = v[0];
            2'd1:    r = v[1];
            default: r = v[2];
        endcase
        return r;
    endfunction

    assign prod_fx = prod_reg >>> rsch_pkg::FRAC_BITS;
    assign acc_sum = acc_reg + prod_fx[ACC_W-1:0];

    // Operand select of the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            rsch_pkg::ST_A:
            begin
                mul_a = pick3(d_reg, cnt_reg);
                mul_b = pick3(d_reg, cnt_reg);
            end
            rsch_pkg::ST_B:
            begin
                mul_a = pick3(oc_reg, cnt_reg);
                mul_b = pick3(d_reg, cnt_reg);
            end
            rsch_pkg::ST_C:
            begin
                mul_a = pick3(oc_reg, cnt_reg);
                mul_b = pick3(oc_reg, cnt_reg);
            end
            rsch_pkg::ST_D:
            begin
                mul_a = (cnt_reg == 2'd0) ? b_reg : a_reg;
                mul_b = (cnt_reg == 2'd0) ? b_reg : cc_reg;
            end
            rsch_pkg::ST_P:
            begin
                mul_a = pick3(d_reg, cnt_reg);
                mul_b = {1'b0, t_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        it_next      = it_reg;
        idx_next     = idx_reg;
        nsph_next    = nsph_reg;
        rsel_next    = rsel_reg;
        found_next   = found_reg;
        o_next       = o_reg;
        d_next       = d_reg;
        oc_next      = oc_reg;
        bp_next      = bp_reg;
        bn_next      = bn_reg;
        acc_next     = acc_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        cc_next      = cc_reg;
        b2_next      = b2_reg;
        rad_next     = rad_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        drem_next    = drem_reg;
        dq_next      = dq_reg;
        t_next       = t_reg;
        best_t_next  = best_t_reg;
        closest_next = closest_reg;
        out_hit_next = out_hit_reg;
        out_t_next   = out_t_reg;
        out_p_next   = out_p_reg;
        out_n_next   = out_n_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        q_ready      = 1'b0;

        disc     = $signed({1'b0, b2_reg}) - {prod_reg[63], prod_reg};
        sq_sh    = {rem_reg, rad_reg[63:62]};
        sq_trial = {2'b00, root_reg, 2'b01};
        sq_diff  = sq_sh - sq_trial;
        num      = rsel_reg ? (-{{2{b_reg[31]}}, b_reg} + $signed({2'b00, root_reg}))
                            : (-{{2{b_reg[31]}}, b_reg} - $signed({2'b00, root_reg}));
        dvd      = {num[NUM_W-2:0], {rsch_pkg::FRAC_BITS{1'b0}}};
        dv_sh    = {drem_reg, dq_reg[30]};
        dv_ge    = (dv_sh >= {1'b0, a_reg[30:0]});
        dv_diff  = dv_sh - {1'b0, a_reg[30:0]};

        unique case (state_reg)
            rsch_pkg::ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid && q_item.is_trace)
                begin
                    o_next[0]    = q_item.pos_x;
                    o_next[1]    = q_item.pos_y;
                    o_next[2]    = q_item.pos_z;
                    d_next[0]    = q_item.dir_x;
                    d_next[1]    = q_item.dir_y;
                    d_next[2]    = q_item.dir_z;
                    nsph_next    = q_item.count;
                    idx_next     = '0;
                    cnt_next     = 2'd0;
                    acc_next     = '0;
                    found_next   = 1'b0;
                    closest_next = 32'h8000_0000;
                    state_next   = rsch_pkg::ST_A;
                end
            end
            rsch_pkg::ST_A, rsch_pkg::ST_B, rsch_pkg::ST_C:
            begin
                // Three products go through the multiplier; each is floored
                // and summed in the cycle after it is issued.
                if (cnt_reg != 2'd0)
                begin
                    acc_next = acc_sum;
                end
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    cnt_next = 2'd0;
                    acc_next = '0;
                    if (state_reg == rsch_pkg::ST_A)
                    begin
                        a_next = rsch_pkg::sat32(64'(acc_sum));
                        if (a_next <= 32'sd0 || nsph_reg == '0)
                        begin
                            state_next = rsch_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = rsch_pkg::ST_RD;
                        end
                    end
                    else if (state_reg == rsch_pkg::ST_B)
                    begin
                        b_next     = rsch_pkg::sat32(64'(acc_sum));
                        state_next = rsch_pkg::ST_C;
                    end
                    else
                    begin
                        cc_next    = rsch_pkg::sat32(64'(acc_sum) - rsch_pkg::FX_ONE);
                        state_next = rsch_pkg::ST_D;
                    end
                end
            end
            rsch_pkg::ST_RD:
            begin
                state_next = rsch_pkg::ST_OC;
            end
            rsch_pkg::ST_OC:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    oc_next[k] = rsch_pkg::sat32(rsch_pkg::ext64(o_reg[k])
                                                 - rsch_pkg::ext64(c_reg[k]));
                end
                cnt_next   = 2'd0;
                state_next = rsch_pkg::ST_B;
            end
            rsch_pkg::ST_D:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd1)
                begin
                    b2_next = prod_reg;
                end
                else if (cnt_reg == 2'd2)
                begin
                    cnt_next = 2'd0;
                    if (disc > 65'sd0)
                    begin
                        rad_next   = disc[63:0];
                        rem_next   = '0;
                        root_next  = '0;
                        it_next    = 5'd31;
                        state_next = rsch_pkg::ST_SQ;
                    end
                    else
                    begin
                        // Grazing or missing ray: move to the next sphere.
                        if (idx_reg + 1'b1 == nsph_reg)
                        begin
                            state_next = rsch_pkg::ST_DONE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = rsch_pkg::ST_RD;
                        end
                    end
                end
            end
            rsch_pkg::ST_SQ:
            begin
                rad_next = {rad_reg[61:0], 2'b00};
                if (sq_sh >= sq_trial)
                begin
                    rem_next  = sq_diff[33:0];
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = sq_sh[33:0];
                    root_next = {root_reg[30:0], 1'b0};
                end
                it_next = it_reg - 5'd1;
                if (it_reg == 5'd0)
                begin
                    rsel_next  = 1'b0;
                    state_next = rsch_pkg::ST_NUM;
                end
            end
            rsch_pkg::ST_NUM:
            begin
                if (num <= 34'sd0)
                begin
                    // A non-positive root never clears the lower t bound.
                    if (!rsel_reg)
                    begin
                        rsel_next = 1'b1;
                    end
                    else if (idx_reg + 1'b1 == nsph_reg)
                    begin
                        state_next = rsch_pkg::ST_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = rsch_pkg::ST_RD;
                    end
                end
                else if ({13'd0, dvd} >= {a_reg[30:0], 31'd0})
                begin
                    t_next     = rsch_pkg::T_MAX;
                    state_next = rsch_pkg::ST_CHK;
                end
                else
                begin
                    drem_next  = {{(31 - (DVD_W - 31)){1'b0}}, dvd[DVD_W-1:31]};
                    dq_next    = dvd[30:0];
                    it_next    = 5'd30;
                    state_next = rsch_pkg::ST_DIV;
                end
            end
            rsch_pkg::ST_DIV:
            begin
                drem_next = dv_ge ? dv_diff[30:0] : dv_sh[30:0];
                dq_next   = {dq_reg[29:0], dv_ge};
                it_next   = it_reg - 5'd1;
                if (it_reg == 5'd0)
                begin
                    t_next     = dq_next;
                    state_next = rsch_pkg::ST_CHK;
                end
            end
            rsch_pkg::ST_CHK:
            begin
                if (t_reg > rsch_pkg::T_MIN && {1'b0, t_reg} < closest_reg)
                begin
                    closest_next = {1'b0, t_reg};
                    best_t_next  = t_reg;
                    found_next   = 1'b1;
                    cnt_next     = 2'd0;
                    state_next   = rsch_pkg::ST_P;
                end
                else if (!rsel_reg)
                begin
                    rsel_next  = 1'b1;
                    state_next = rsch_pkg::ST_NUM;
                end
                else if (idx_reg + 1'b1 == nsph_reg)
                begin
                    state_next = rsch_pkg::ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = rsch_pkg::ST_RD;
                end
            end
            rsch_pkg::ST_P:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (2'(k + 1) == cnt_reg)
                    begin
                        bp_next[k] = rsch_pkg::sat32(rsch_pkg::ext64(o_reg[k]) + prod_fx);
                    end
                end
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    cnt_next   = 2'd0;
                    state_next = rsch_pkg::ST_NRM;
                end
            end
            rsch_pkg::ST_NRM:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    bn_next[k] = rsch_pkg::sat32(rsch_pkg::ext64(bp_reg[k])
                                                 - rsch_pkg::ext64(c_reg[k]));
                end
                if (idx_reg + 1'b1 == nsph_reg)
                begin
                    state_next = rsch_pkg::ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = rsch_pkg::ST_RD;
                end
            end
            rsch_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    out_hit_next   = found_reg;
                    out_t_next     = found_reg ? best_t_reg : '0;
                    for (int k = 0; k < 3; k++)
                    begin
                        out_p_next[k] = found_reg ? bp_reg[k] : 32'sd0;
                        out_n_next[k] = found_reg ? bn_reg[k] : 32'sd0;
                    end
                    state_next = rsch_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rsch_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rsch_pkg::ST_IDLE;
            cnt_reg       <= 2'd0;
            it_reg        <= 5'd0;
            idx_reg       <= '0;
            nsph_reg      <= '0;
            rsel_reg      <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            it_reg        <= it_next;
            idx_reg       <= idx_next;
            nsph_reg      <= nsph_next;
            rsel_reg      <= rsel_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= mul_a * mul_b;
        o_reg       <= o_next;
        d_reg       <= d_next;
        oc_reg      <= oc_next;
        bp_reg      <= bp_next;
        bn_reg      <= bn_next;
        acc_reg     <= acc_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        cc_reg      <= cc_next;
        b2_reg      <= b2_next;
        rad_reg     <= rad_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        drem_reg    <= drem_next;
        dq_reg      <= dq_next;
        t_reg       <= t_next;
        best_t_reg  <= best_t_next;
        closest_reg <= closest_next;
        out_hit_reg <= out_hit_next;
        out_t_reg   <= out_t_next;
        out_p_reg   <= out_p_next;
        out_n_reg   <= out_n_next;
    end

    // Table write on a load item, registered read of the current sphere.
    always_ff @(posedge clk)
    begin
        if (state_reg == rsch_pkg::ST_IDLE && q_valid && !q_item.is_trace)
        begin
            tab_x[q_item.index] <= q_item.pos_x;
            tab_y[q_item.index] <= q_item.pos_y;
            tab_z[q_item.index] <= q_item.pos_z;
        end
        if (state_reg == rsch_pkg::ST_RD)
        begin
            c_reg[0] <= tab_x[idx_reg[rsch_pkg::IDX_W-1:0]];
            c_reg[1] <= tab_y[idx_reg[rsch_pkg::IDX_W-1:0]];
            c_reg[2] <= tab_z[idx_reg[rsch_pkg::IDX_W-1:0]];
        end
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.hit      = out_hit_reg;
    assign rsp.hit_t    = out_t_reg;
    assign rsp.point_x  = out_p_reg[0];
    assign rsp.point_y  = out_p_reg[1];
    assign rsp.point_z  = out_p_reg[2];
    assign rsp.normal_x = out_n_reg[0];
    assign rsp.normal_y = out_n_reg[1];
    assign rsp.normal_z = out_n_reg[2];

endmodule
`default_nettype wire

// File: hdl/ray_sphere_closest_hit_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit_top: ray versus unit-sphere closest-hit engine
// Loads sphere centers and answers each trace item with the nearest hit.
// ----------------------------------------------------------------------------
// A load item (opcode 0) writes one Q16.16 sphere center into a 16-entry
// table and gives no result; a trace item (opcode 1) tests the ray against
// the first sphere_count entries and gives exactly one result: hit, the
// nearest t above 0.001, the hit point and the normal (point minus center),
// or all zeros on a miss. Items are queued in a two-entry FIFO, so the
// request side can take up to two items while a trace runs or a result
// waits. A load is written into the table by the sequencer while idle.
// A trace leaves the queue and computes D.D, then per sphere reads the
// center, forms the dot products and discriminant, runs a bit-serial
// square root when the discriminant is positive, and for each root tried
// a bit-serial division and check, plus the hit point and normal when a
// closer hit is found; the square root and divider loops and the single
// shared 32x32 multiplier set its pace. A last step moves the result into
// the output register once that register is free. Never-written table
// entries read as undefined values.
// ----------------------------------------------------------------------------
module ray_sphere_closest_hit_top
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [rsch_pkg::CNT_W-1:0] cfg_wr_data,
    rsch_req_if.sink                        req,
    rsch_rsp_if.source                      rsp
);

    logic            q_valid;
    logic            q_ready;
    rsch_pkg::item_t q_item;

    // Intake: count register, classification and the item queue.
    rsch_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    // Execution: table, sequencer and the result register.
    rsch_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .rsp     (rsp)
    );

    // A miss result carries zeros in every field.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.hit) |-> (rsp.hit_t == '0 && rsp.point_x == '0 &&
            rsp.point_y == '0 && rsp.point_z == '0 && rsp.normal_x == '0 &&
            rsp.normal_y == '0 && rsp.normal_z == '0))
        else $error("miss result with nonzero payload");

    // A hit always lies beyond the lower t bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hit) |-> (rsp.hit_t > rsch_pkg::T_MIN))
        else $error("hit at or below the lower t bound");

    // A stalled request side means the queue holds work for the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> q_valid)
        else $error("request stalled with an empty queue");

endmodule
`default_nettype wire

// File: sim/ray_sphere_closest_hit_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit_checker: closest-hit predictor and result checker
// Watches the request, response and configuration ports, keeps its own copy
// of the sphere table and count, and compares every result with the oldest
// expected hit record.
// ----------------------------------------------------------------------------
module ray_sphere_closest_hit_checker
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [rsch_pkg::CNT_W-1:0] cfg_wr_data,
    rsch_req_if                             req,
    rsch_rsp_if                             rsp,
    output int                              error_count,
    output int                              hits_pending
);

    typedef struct
    {
        logic                     hit;
        logic [rsch_pkg::T_W-1:0] hit_t;
        logic [31:0]              point[3];
        logic [31:0]              normal[3];
    } hit_rec_t;

    longint        center_tab[rsch_pkg::MAX_SPHERES][3];
    int unsigned   active_count;
    hit_rec_t      expected_hits[$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sh7FFF_FFFF)
        begin
            return 64'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000)
        begin
            return -64'sh8000_0000;
        end
        return v;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Walk the active spheres in index order and keep the nearest root.
    function automatic hit_rec_t trace_closest(input longint o[3], input longint d[3]);
        hit_rec_t    r;
        longint      oc[3];
        longint      a, b, c, ac, sq, num, t, closest, bp;
        logic [63:0] b2, disc;
        int          n;
        r.hit = 0;
        r.hit_t = '0;
        for (int k = 0; k < 3; k++)
        begin
            r.point[k] = '0;
            r.normal[k] = '0;
        end
        closest = 64'sh8000_0000;
        n = (active_count > rsch_pkg::MAX_SPHERES) ? rsch_pkg::MAX_SPHERES : active_count;
        for (int i = 0; i < n; i++)
        begin
            a = 0;
            b = 0;
            c = 0;
            for (int k = 0; k < 3; k++)
            begin
                oc[k] = clamp32(o[k] - center_tab[i][k]);
                a += (d[k] * d[k]) >>> rsch_pkg::FRAC_BITS;
                b += (oc[k] * d[k]) >>> rsch_pkg::FRAC_BITS;
                c += (oc[k] * oc[k]) >>> rsch_pkg::FRAC_BITS;
            end
            a = clamp32(a);
            b = clamp32(b);
            c = clamp32(c - (64'sd1 <<< rsch_pkg::FRAC_BITS));
            if (a <= 0)
            begin
                continue;
            end
            b2 = b * b;
            ac = a * c;
            if (ac <= 0)
            begin
                disc = b2 + 64'(-ac);
            end
            else if (b2 > 64'(ac))
            begin
                disc = b2 - 64'(ac);
            end
            else
            begin
                continue;
            end
            if (disc == 0)
            begin
                continue;
            end
            sq = longint'(floor_sqrt(disc));
            for (int root = 0; root < 2; root++)
            begin
                num = (root == 0) ? (-b - sq) : (-b + sq);
                t = (num * (64'sd1 <<< rsch_pkg::FRAC_BITS)) / a;
                if (t > 64'sh7FFF_FFFF)
                begin
                    t = 64'sh7FFF_FFFF;
                end
                if (t > longint'(rsch_pkg::T_MIN) && t < closest)
                begin
                    closest = t;
                    r.hit = 1;
                    r.hit_t = t[rsch_pkg::T_W-1:0];
                    for (int k = 0; k < 3; k++)
                    begin
                        bp = clamp32(o[k] + ((d[k] * t) >>> rsch_pkg::FRAC_BITS));
                        r.point[k] = bp[31:0];
                        bp = clamp32(bp - center_tab[i][k]);
                        r.normal[k] = bp[31:0];
                    end
                    break;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    assign hits_pending = expected_hits.size();

    always @(posedge clk or negedge rst_n)
    begin
        longint   o[3];
        longint   d[3];
        hit_rec_t want;
        logic [31:0] got_p[3];
        logic [31:0] got_n[3];
        if (!rst_n)
        begin
            active_count <= 0;
            error_count = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                active_count <= cfg_wr_data;
            end
            if (req.valid && req.ready)
            begin
                o[0] = req.pos_x;
                o[1] = req.pos_y;
                o[2] = req.pos_z;
                d[0] = req.dir_x;
                d[1] = req.dir_y;
                d[2] = req.dir_z;
                if (rsch_pkg::op_t'(req.opcode) == rsch_pkg::OP_LOAD)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        center_tab[req.sphere_index][k] = o[k];
                    end
                end
                else
                begin
                    expected_hits.push_back(trace_closest(o, d));
                end
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    report_mismatch("result with no trace outstanding", 64'd1, 64'd0);
                end
                else
                begin
                    want = expected_hits.pop_front();
                    got_p[0] = rsp.point_x;
                    got_p[1] = rsp.point_y;
                    got_p[2] = rsp.point_z;
                    got_n[0] = rsp.normal_x;
                    got_n[1] = rsp.normal_y;
                    got_n[2] = rsp.normal_z;
                    if (rsp.hit !== want.hit)
                    begin
                        report_mismatch("hit", rsp.hit, want.hit);
                    end
                    if (rsp.hit_t !== want.hit_t)
                    begin
                        report_mismatch("hit_t", rsp.hit_t, want.hit_t);
                    end
                    for (int k = 0; k < 3; k++)
                    begin
                        if (got_p[k] !== want.point[k])
                        begin
                            report_mismatch($sformatf("point[%0d]", k), got_p[k], want.point[k]);
                        end
                        if (got_n[k] !== want.normal[k])
                        begin
                            report_mismatch($sformatf("normal[%0d]", k), got_n[k],
                                            want.normal[k]);
                        end
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: sim/ray_sphere_closest_hit_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit_top_tb: testbench of the ray/sphere closest-hit engine
// Loads sphere tables, traces directed and aimed random rays under several
// sphere counts and handshake idling patterns, and lets the checker judge
// every result.
// ----------------------------------------------------------------------------
module ray_sphere_closest_hit_top_tb;

    // Cycles without any accepted item before the run is declared hung. The
    // slowest trace walks all sixteen spheres.
    localparam int STALL_LIMIT = 20000;
    // Settling time once the last result is in; a load may still be queued.
    localparam int DRAIN_CYCLES = 50;
    localparam int RANDOM_ITEMS = 480;
    localparam int UNIT = 1 << rsch_pkg::FRAC_BITS;

    typedef struct
    {
        rsch_pkg::op_t opcode;
        logic [3:0]    index;
        logic [31:0]   pos[3];
        logic [31:0]   dir[3];
    } ray_item_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [rsch_pkg::CNT_W-1:0] cfg_wr_data;
    int                         error_count;
    int                         hits_pending;
    int                         send_idle_pct;
    int                         recv_idle_pct;
    int                         quiet_cycles;
    int                         spheres_live;

    // The stimulus side keeps the loaded centers so that it can aim rays.
    logic signed [31:0]   center_copy[16][3];

    rsch_req_if req ();
    rsch_rsp_if rsp ();

    ray_sphere_closest_hit_top DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .rsp         (rsp)
    );

    ray_sphere_closest_hit_checker hit_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .req          (req),
        .rsp          (rsp),
        .error_count  (error_count),
        .hits_pending (hits_pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The receiver stalls at random with the current idle percentage.
    always @(posedge clk)
    begin
        rsp.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: any accepted item on either channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Present one item, with a random gap first, and hold it until accepted.
    task automatic send_item(input ray_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.opcode       <= it.opcode;
        req.sphere_index <= it.index;
        req.pos_x        <= it.pos[0];
        req.pos_y        <= it.pos[1];
        req.pos_z        <= it.pos[2];
        req.dir_x        <= it.dir[0];
        req.dir_y        <= it.dir[1];
        req.dir_z        <= it.dir[2];
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        if (it.opcode == rsch_pkg::OP_LOAD)
        begin
            for (int k = 0; k < 3; k++)
            begin
                center_copy[it.index][k] = it.pos[k];
            end
        end
    endtask

    task automatic load_center(input int idx, input int x, input int y, input int z);
        ray_item_t it;
        it.opcode = rsch_pkg::OP_LOAD;
        it.index = idx[3:0];
        it.pos[0] = x;
        it.pos[1] = y;
        it.pos[2] = z;
        for (int k = 0; k < 3; k++)
        begin
            it.dir[k] = $urandom();
        end
        send_item(it);
    endtask

    task automatic trace_ray(input int ox, input int oy, input int oz,
                             input int dx, input int dy, input int dz);
        ray_item_t it;
        it.opcode = rsch_pkg::OP_TRACE;
        it.index = 4'($urandom_range(15));
        it.pos[0] = ox;
        it.pos[1] = oy;
        it.pos[2] = oz;
        it.dir[0] = dx;
        it.dir[1] = dy;
        it.dir[2] = dz;
        send_item(it);
    endtask

    // Wait for every result, let a trailing load settle, then write the count.
    task automatic set_sphere_count(input int value);
        req.valid <= 1'b0;
        @(posedge clk);
        while (hits_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[rsch_pkg::CNT_W-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        spheres_live = (value > rsch_pkg::MAX_SPHERES) ? rsch_pkg::MAX_SPHERES : value;
    endtask

    function automatic int small_offset(input int span_units);
        return int'($urandom_range(2 * span_units * UNIT)) - span_units * UNIT;
    endfunction

    // One random item: mostly rays aimed at a live sphere, some reloads of
    // nearby centers, and some fully random noise.
    task automatic random_item();
        int j;
        int orig[3];
        int roll;
        roll = $urandom_range(99);
        if (roll < 15)
        begin
            load_center($urandom_range(15), small_offset(16), small_offset(16),
                        small_offset(16));
        end
        else if (roll < 25)
        begin
            if ($urandom_range(1) == 0)
            begin
                load_center($urandom_range(15), $urandom(), $urandom(), $urandom());
            end
            else
            begin
                trace_ray($urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom());
            end
        end
        else
        begin
            j = (spheres_live == 0) ? $urandom_range(15) : $urandom_range(spheres_live - 1);
            for (int k = 0; k < 3; k++)
            begin
                // Some rays start inside or right at the sphere.
                orig[k] = center_copy[j][k] + ((roll < 35) ? small_offset(1) : small_offset(10));
            end
            trace_ray(orig[0], orig[1], orig[2],
                      (center_copy[j][0] - orig[0] + small_offset(1) / 2) >>> $urandom_range(3),
                      (center_copy[j][1] - orig[1] + small_offset(1) / 2) >>> $urandom_range(3),
                      (center_copy[j][2] - orig[2] + small_offset(1) / 2) >>> $urandom_range(3));
        end
    endtask

    initial
    begin
        int counts[8];
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        req.valid      = 1'b0;
        req.opcode     = 1'b0;
        req.sphere_index = '0;
        req.pos_x      = '0;
        req.pos_y      = '0;
        req.pos_z      = '0;
        req.dir_x      = '0;
        req.dir_y      = '0;
        req.dir_z      = '0;
        spheres_live   = 0;
        send_idle_pct  = 28;
        recv_idle_pct  = 67;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A trace before any count is written tests no sphere: a miss.
        trace_ray(0, 0, -5 * UNIT, 0, 0, UNIT);

        // Fill the whole table. The last two entries sit at the extremes.
        load_center(0, 0, 0, 0);
        for (int i = 1; i < 14; i++)
        begin
            load_center(i, small_offset(16), small_offset(16), small_offset(16));
        end
        load_center(14, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        load_center(15, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        set_sphere_count(rsch_pkg::MAX_SPHERES);

        trace_ray(0, 0, -5 * UNIT, 0, 0, UNIT);              // straight at the origin sphere
        trace_ray(0, 0, -5 * UNIT, 0, 0, 0);                 // zero direction is skipped
        trace_ray(0, 1 * UNIT, -5 * UNIT, 0, 0, UNIT);       // tangent ray grazes sphere 0
        trace_ray(0, 0, 0, UNIT, 0, 0);                      // origin inside a sphere
        trace_ray(0, 0, 5 * UNIT, 0, 0, UNIT);               // sphere lies behind the ray
        trace_ray(0, 0, -100 * UNIT, 0, 0, 1);               // tiny direction floors D.D to zero: a miss
        trace_ray(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        trace_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        trace_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1, 1);

        // Random phases across counts, including zero and an over-range count.
        counts = '{1, 3, 31, 0, 2, 5, 16, 4};
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % (RANDOM_ITEMS / 8) == 0)
            begin
                set_sphere_count(counts[n / (RANDOM_ITEMS / 8)]);
            end
            if (n == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 67;
                recv_idle_pct = 28;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_item();
        end
        req.valid <= 1'b0;

        while (hits_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: ray_sphere_closest_hit_top.f
hdl/rsch_pkg.sv
hdl/rsch_if.sv
hdl/rsch_front.sv
hdl/rsch_back.sv
hdl/ray_sphere_closest_hit_top.sv
sim/ray_sphere_closest_hit_checker.sv
sim/ray_sphere_closest_hit_top_tb.sv
